@@ hw/rtl/cqra_pkg.sv @@
package cqra_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int ENTRY_WIDTH_DEF = 64;

    localparam int DATA_W      = 64;
    localparam int POS_W       = 4;
    localparam int COUNT_W     = 5;
    localparam int IDX_MAX_W   = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } action_t;

    typedef enum logic [1:0]
    {
        ST_ADDED   = 2'd0,
        ST_FULL    = 2'd1,
        ST_REMOVED = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0]
    {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_SHIFT = 2'd2
    } cmd_kind_t;

    typedef enum logic [1:0]
    {
        BK_IDLE  = 2'd0,
        BK_SHIFT = 2'd1,
        BK_EMIT  = 2'd2
    } back_state_t;

    typedef struct packed
    {
        status_t              status;
        logic [COUNT_W-1:0]   entry_count;
        logic                 is_empty;
        logic                 is_full;
    } result_t;

    typedef struct packed
    {
        cmd_kind_t              kind;
        logic [IDX_MAX_W-1:0]   slot;
        logic [IDX_MAX_W-1:0]   moves;
        logic [DATA_W-1:0]      data;
        result_t                res;
    } cmd_t;

endpackage

@@ hw/rtl/cqra_req_if.sv @@
interface cqra_req_if;

    logic                           valid;
    logic                           ready;
    logic                           action;
    logic [cqra_pkg::DATA_W-1:0]    entry_data;
    logic [cqra_pkg::POS_W-1:0]     position;

    modport source
    (
        output valid,
        output action,
        output entry_data,
        output position,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  action,
        input  entry_data,
        input  position,
        output ready
    );

endinterface

@@ hw/rtl/cqra_rsp_if.sv @@
interface cqra_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [1:0]                     status;
    logic [cqra_pkg::COUNT_W-1:0]   entry_count;
    logic                           is_empty;
    logic                           is_full;

    modport source
    (
        output valid,
        output status,
        output entry_count,
        output is_empty,
        output is_full,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  status,
        input  entry_count,
        input  is_empty,
        input  is_full,
        output ready
    );

endinterface

@@ hw/rtl/cqra_front.sv @@
module cqra_front
#(
    parameter int DEPTH = cqra_pkg::DEPTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    cqra_req_if.sink         req,
    output cqra_pkg::cmd_t   cmd,
    output logic             cmd_push,
    input  logic             cmd_full
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > cqra_pkg::POS_W) ? CNT_W : cqra_pkg::POS_W;
    localparam int SUM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] cnt_cmp;
    logic [CMP_W-1:0] moves_cmp;
    logic [SUM_W-1:0] slot_sum;
    logic [IDX_W-1:0] slot_idx;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - IDX_W'(1);
    endfunction

    assign req.ready = !cmd_full;
    assign accept    = req.valid && req.ready;
    assign cmd_push  = accept;

    always_comb
    begin
        pos_cmp   = CMP_W'(req.position);
        cnt_cmp   = CMP_W'(count_reg);
        moves_cmp = cnt_cmp - CMP_W'(1) - pos_cmp;
        slot_sum  = SUM_W'(head_reg) + SUM_W'(req.position);
        if (slot_sum >= SUM_W'(DEPTH))
        begin
            slot_sum = slot_sum - SUM_W'(DEPTH);
        end
        slot_idx = IDX_W'(slot_sum);

        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        cmd        = '0;
        cmd.kind   = cqra_pkg::CMD_NONE;
        cmd.data   = req.entry_data;
        cmd.res.status = cqra_pkg::ST_INVALID;

        if (req.action == cqra_pkg::ACT_INSERT)
        begin
            if (count_reg == DEPTH_CNT)
            begin
                cmd.res.status = cqra_pkg::ST_FULL;
            end
            else
            begin
                tail_next      = idx_next(tail_reg);
                count_next     = count_reg + CNT_W'(1);
                cmd.kind       = cqra_pkg::CMD_WRITE;
                cmd.slot       = cqra_pkg::IDX_MAX_W'(tail_next);
                cmd.res.status = cqra_pkg::ST_ADDED;
            end
        end
        else if (count_reg != '0 && pos_cmp < cnt_cmp)
        begin
            cmd.res.status = cqra_pkg::ST_REMOVED;
            count_next     = count_reg - CNT_W'(1);
            if (count_reg == CNT_W'(1))
            begin
                head_next = '0;
                tail_next = LAST_IDX;
            end
            else if (pos_cmp == '0)
            begin
                head_next = idx_next(head_reg);
            end
            else
            begin
                tail_next = idx_prev(tail_reg);
                if (moves_cmp != '0)
                begin
                    cmd.kind  = cqra_pkg::CMD_SHIFT;
                    cmd.slot  = cqra_pkg::IDX_MAX_W'(slot_idx);
                    cmd.moves = cqra_pkg::IDX_MAX_W'(moves_cmp);
                end
            end
        end

        cmd.res.entry_count = cqra_pkg::COUNT_W'(count_next);
        cmd.res.is_empty    = (count_next == '0);
        cmd.res.is_full     = (count_next == DEPTH_CNT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= LAST_IDX;
            count_reg <= '0;
        end
        else if (accept)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && req.action == cqra_pkg::ACT_INSERT && count_reg != DEPTH_CNT
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("count did not advance on insert");

    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == '0 && tail_reg == LAST_IDX)
        else $error("empty ring away from reset pointers");

endmodule

@@ hw/rtl/cqra_cmd_queue.sv @@
module cqra_cmd_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  cqra_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output cqra_pkg::cmd_t   pop_cmd,
    output logic             empty
);

    cqra_pkg::cmd_t                    slot_reg [cqra_pkg::QUEUE_DEPTH];
    logic [cqra_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [cqra_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [cqra_pkg::QFILL_W-1:0]      fill_reg;
    logic [cqra_pkg::QFILL_W-1:0]      fill_next;

    assign full    = (fill_reg == cqra_pkg::QFILL_W'(cqra_pkg::QUEUE_DEPTH));
    assign empty   = (fill_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + cqra_pkg::QFILL_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - cqra_pkg::QFILL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + cqra_pkg::QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + cqra_pkg::QPTR_W'(1);
            end
            fill_reg <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("pop from empty command queue");

endmodule

@@ hw/rtl/cqra_back.sv @@
module cqra_back
#(
    parameter int DEPTH       = cqra_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = cqra_pkg::ENTRY_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cqra_pkg::cmd_t   cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    cqra_rsp_if.source       rsp
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    cqra_pkg::back_state_t   state_reg;
    cqra_pkg::back_state_t   state_next;
    logic [IDX_W-1:0]        wr_slot_reg;
    logic [IDX_W-1:0]        wr_slot_next;
    logic [IDX_W-1:0]        rd_slot_reg;
    logic [IDX_W-1:0]        rd_slot_next;
    logic [IDX_W-1:0]        rem_reg;
    logic [IDX_W-1:0]        rem_next;
    cqra_pkg::result_t       cur_res_reg;
    cqra_pkg::result_t       cur_res_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    cqra_pkg::result_t       out_res_reg;
    cqra_pkg::result_t       out_res_next;
    logic                    out_free;
    logic                    load_out;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_wa;
    logic [ENTRY_WIDTH-1:0]  mem_wd;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic [ENTRY_WIDTH-1:0]  rd_data_reg;
    logic [ENTRY_WIDTH-1:0]  mem [DEPTH];

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
    endfunction

    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cqra_pkg::BK_IDLE:
            begin
                if (!cmd_empty && out_free && cmd.kind == cqra_pkg::CMD_SHIFT)
                begin
                    state_next = cqra_pkg::BK_SHIFT;
                end
            end
            cqra_pkg::BK_SHIFT:
            begin
                if (rem_reg == '0)
                begin
                    state_next = cqra_pkg::BK_EMIT;
                end
            end
            cqra_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    state_next = cqra_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = cqra_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop      = 1'b0;
        load_out     = 1'b0;
        out_res_next = out_res_reg;
        cur_res_next = cur_res_reg;
        mem_we       = 1'b0;
        mem_wa       = wr_slot_reg;
        mem_wd       = rd_data_reg;
        rd_en        = 1'b0;
        rd_addr      = idx_next(rd_slot_reg);
        wr_slot_next = wr_slot_reg;
        rd_slot_next = rd_slot_reg;
        rem_next     = rem_reg;
        case (state_reg)
            cqra_pkg::BK_IDLE:
            begin
                cmd_pop = !cmd_empty && out_free;
                if (cmd_pop)
                begin
                    case (cmd.kind)
                        cqra_pkg::CMD_WRITE:
                        begin
                            mem_we       = 1'b1;
                            mem_wa       = IDX_W'(cmd.slot);
                            mem_wd       = ENTRY_WIDTH'(cmd.data);
                            load_out     = 1'b1;
                            out_res_next = cmd.res;
                        end
                        cqra_pkg::CMD_SHIFT:
                        begin
                            rd_en        = 1'b1;
                            rd_addr      = idx_next(IDX_W'(cmd.slot));
                            wr_slot_next = IDX_W'(cmd.slot);
                            rd_slot_next = rd_addr;
                            rem_next     = IDX_W'(cmd.moves) - IDX_W'(1);
                            cur_res_next = cmd.res;
                        end
                        default:
                        begin
                            load_out     = 1'b1;
                            out_res_next = cmd.res;
                        end
                    endcase
                end
            end
            cqra_pkg::BK_SHIFT:
            begin
                mem_we       = 1'b1;
                wr_slot_next = rd_slot_reg;
                if (rem_reg != '0)
                begin
                    rd_en        = 1'b1;
                    rd_slot_next = rd_addr;
                    rem_next     = rem_reg - IDX_W'(1);
                end
            end
            cqra_pkg::BK_EMIT:
            begin
                if (out_free)
                begin
                    load_out     = 1'b1;
                    out_res_next = cur_res_reg;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
        out_valid_next = load_out ? 1'b1 : (out_valid_reg && !rsp.ready);
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        wr_slot_reg <= wr_slot_next;
        rd_slot_reg <= rd_slot_next;
        rem_reg     <= rem_next;
        cur_res_reg <= cur_res_next;
        out_res_reg <= out_res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cqra_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_res_reg.status;
    assign rsp.entry_count = out_res_reg.entry_count;
    assign rsp.is_empty    = out_res_reg.is_empty;
    assign rsp.is_full     = out_res_reg.is_full;

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp.ready |-> !load_out)
        else $error("pending result overwritten");

    a_busy_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != cqra_pkg::BK_IDLE |-> !cmd_pop)
        else $error("command taken while shifting");

endmodule

@@ hw/rtl/circular_queue_remove_at_top.sv @@
// Channel  Modport  Payload                                           Handshake
// req      sink     action, entry_data[63:0], position[3:0]           valid/ready
// rsp      source   status[1:0], entry_count[4:0], is_empty, is_full  valid/ready
//
// Insert, reject and head or tail removal: result registered via the command queue and the rsp register.
// Middle removal: count-1-position entries are moved, one entry per cycle
// through the single write port of the entry memory, then the result is emitted.
// Reset is asynchronous; the entry memory is not cleared, req is ready at once.
// A two-item command queue keeps req open while the back end shifts; req
// stalls when it fills; the back end neither takes a command nor emits while rsp holds a result.
module circular_queue_remove_at_top
#(
    parameter int DEPTH       = cqra_pkg::DEPTH_DEF,
    parameter int ENTRY_WIDTH = cqra_pkg::ENTRY_WIDTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    cqra_req_if.sink     req,
    cqra_rsp_if.source   rsp
);

    cqra_pkg::cmd_t   push_cmd;
    cqra_pkg::cmd_t   pop_cmd;
    logic             push;
    logic             pop;
    logic             full;
    logic             empty;

    cqra_front
    #(
        .DEPTH (DEPTH)
    )
    u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cmd      (push_cmd),
        .cmd_push (push),
        .cmd_full (full)
    );

    cqra_cmd_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (empty)
    );

    cqra_back
    #(
        .DEPTH       (DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (pop_cmd),
        .cmd_empty (empty),
        .cmd_pop   (pop),
        .rsp       (rsp)
    );

endmodule
